>>> hw/rtl/neighbor_link_table_with_aging_macros.svh
// ============================================================================
// Assertion macros for the neighbour link table
// Implication and next-cycle checks, clocked on i_clk, disabled in reset.
// ============================================================================
`ifndef NEIGHBOR_LINK_TABLE_WITH_AGING_MACROS_SVH
`define NEIGHBOR_LINK_TABLE_WITH_AGING_MACROS_SVH

// Check that cons holds in the cycle where ante holds
`define NLTA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds
`define NLTA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nlta_pkg.sv
// ============================================================================
// nlta_pkg
// Shared types and constants of the neighbour link table with ageing.
// ============================================================================
`default_nettype none

package nlta_pkg;

    // Table geometry and field widths
    localparam int PORT_COUNT = 64;
    localparam int PORT_W     = 6;
    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int SEQ_W      = 32;
    localparam int CNT_W      = 7;
    localparam int ENTRY_W    = MAC_W + TIME_W;

    localparam logic [TIME_W-1:0] STALE_TIMEOUT_RST = 32'd10000;

    // Operation codes
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_SWEEP  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RPT_CHK,
        S_STAT,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/nlta_ram.sv
// ============================================================================
// nlta_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module nlta_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/neighbor_link_table_with_aging.sv
// ============================================================================
// neighbor_link_table_with_aging
// Per-port neighbour link table with timestamp ageing and advert stamping.
// ============================================================================
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -----------------------------------
//  in       sink       i_in_valid / o_in_stall   op, port_index, nbr_mac, ...
//  out      source     o_out_valid / i_out_stall adv_*, found, found_port, removed
//  cfg      sink       i_cfg_we                  i_cfg_data (stale timeout, ms)
//
//  One item at a time. A report passes S_READ, S_RPT_CHK and S_DONE; a port
//  status passes S_STAT and S_DONE. A sweep reads every entry through the single
//  RAM read port. A lookup stops at its first match.
//  Reset clears valid, known and up flags at once; no clearing pass.
//  A new item is taken while the last result waits; a stalled output holds
//  the sequencer in its final state until the result slot frees.
// ============================================================================
`default_nettype none

module neighbor_link_table_with_aging (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [nlta_pkg::TIME_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_op,
    input  wire logic [nlta_pkg::PORT_W-1:0] i_port_index,
    input  wire logic [nlta_pkg::MAC_W-1:0]  i_nbr_mac,
    input  wire logic                        i_port_online,
    input  wire logic [nlta_pkg::TIME_W-1:0] i_now_ms,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_adv_sent,
    output logic      [nlta_pkg::TIME_W-1:0] o_adv_time,
    output logic      [nlta_pkg::SEQ_W-1:0]  o_adv_seq,
    output logic                             o_found,
    output logic      [nlta_pkg::PORT_W-1:0] o_found_port,
    output logic      [nlta_pkg::CNT_W-1:0]  o_stale_removed
);

    localparam logic [nlta_pkg::PORT_W-1:0] LAST_PORT =
        nlta_pkg::PORT_W'(nlta_pkg::PORT_COUNT - 1);

    // Control state
    nlta_pkg::t_state                  r_state, n_state;
    logic                              r_out_valid;
    logic [nlta_pkg::PORT_COUNT-1:0]   r_link_valid;
    logic [nlta_pkg::PORT_COUNT-1:0]   r_port_known;
    logic [nlta_pkg::PORT_COUNT-1:0]   r_port_up;
    logic [nlta_pkg::TIME_W-1:0]       r_adv_time;
    logic [nlta_pkg::SEQ_W-1:0]        r_adv_seq;
    logic [nlta_pkg::TIME_W-1:0]       r_timeout;
    logic [nlta_pkg::PORT_W-1:0]       r_idx;
    logic                              r_chk_pend;

    // Item and result payload
    nlta_pkg::t_op                     r_op;
    logic [nlta_pkg::PORT_W-1:0]       r_port;
    logic [nlta_pkg::MAC_W-1:0]        r_mac;
    logic                              r_online;
    logic [nlta_pkg::TIME_W-1:0]       r_now;
    logic [nlta_pkg::PORT_W-1:0]       r_chk_idx;
    logic                              r_res_adv;
    logic                              r_res_found;
    logic [nlta_pkg::PORT_W-1:0]       r_res_port;
    logic [nlta_pkg::CNT_W-1:0]        r_removed;

    // Memory interface
    logic                              w_mem_we;
    logic [nlta_pkg::PORT_W-1:0]       w_mem_raddr;
    logic [nlta_pkg::ENTRY_W-1:0]      w_mem_rdata;
    logic [nlta_pkg::MAC_W-1:0]        w_rd_mac;
    logic [nlta_pkg::TIME_W-1:0]       w_rd_stamp;

    // Decisions
    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_chk_act;
    logic                              w_hit;
    logic                              w_stale;
    logic                              w_rpt_chg;
    logic                              w_stat_chg;
    logic                              w_adv_later;
    logic [nlta_pkg::TIME_W-1:0]       w_adv_time;
    logic [nlta_pkg::SEQ_W-1:0]        w_adv_seq;

    // Entry store: neighbour MAC over last-report stamp
    nlta_ram #(
        .WIDTH (nlta_pkg::ENTRY_W),
        .DEPTH (nlta_pkg::PORT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_port),
        .i_wdata ({r_mac, r_now}),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign w_rd_mac   = w_mem_rdata[nlta_pkg::ENTRY_W-1:nlta_pkg::TIME_W];
    assign w_rd_stamp = w_mem_rdata[nlta_pkg::TIME_W-1:0];

    // Handshakes
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != nlta_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    // Compare the entry read in the previous scan cycle
    assign w_chk_act = r_chk_pend &&
                       ((r_state == nlta_pkg::S_SCAN) || (r_state == nlta_pkg::S_DRAIN));
    assign w_hit     = w_chk_act && r_link_valid[r_chk_idx] && (w_rd_mac == r_mac);
    assign w_stale   = w_chk_act && r_link_valid[r_chk_idx] && (w_rd_stamp <= r_now) &&
                       ((r_now - w_rd_stamp) > r_timeout);

    // Report changes the link when the entry is new or the MAC moved
    assign w_rpt_chg  = !r_link_valid[r_port] || (w_rd_mac != r_mac);
    assign w_stat_chg = !r_port_known[r_port] || (r_port_up[r_port] != r_online);

    // Advert stamp: a later time restarts the sequence, else count on
    assign w_adv_later = r_now > r_adv_time;
    assign w_adv_time  = w_adv_later ? r_now : r_adv_time;
    assign w_adv_seq   = w_adv_later ? '0 : r_adv_seq + 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nlta_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (nlta_pkg::t_op'(i_op))
                        nlta_pkg::OP_REPORT: n_state = nlta_pkg::S_READ;
                        nlta_pkg::OP_SWEEP:  n_state = nlta_pkg::S_SCAN;
                        nlta_pkg::OP_LOOKUP: n_state = nlta_pkg::S_SCAN;
                        nlta_pkg::OP_STATUS: n_state = nlta_pkg::S_STAT;
                        default:             n_state = nlta_pkg::S_IDLE;
                    endcase
                end
            end
            nlta_pkg::S_READ:    n_state = nlta_pkg::S_RPT_CHK;
            nlta_pkg::S_RPT_CHK: n_state = nlta_pkg::S_DONE;
            nlta_pkg::S_STAT:    n_state = nlta_pkg::S_DONE;
            nlta_pkg::S_SCAN: begin
                priority if ((r_op == nlta_pkg::OP_LOOKUP) && w_hit) begin
                    n_state = nlta_pkg::S_DONE;
                end else if (r_idx == LAST_PORT) begin
                    n_state = nlta_pkg::S_DRAIN;
                end
            end
            nlta_pkg::S_DRAIN:   n_state = nlta_pkg::S_DONE;
            nlta_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = nlta_pkg::S_IDLE;
                end
            end
            default:             n_state = nlta_pkg::S_IDLE;
        endcase
    end

    // Memory controls
    always_comb begin
        w_mem_we    = (r_state == nlta_pkg::S_RPT_CHK);
        w_mem_raddr = (r_state == nlta_pkg::S_READ) ? r_port : r_idx;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nlta_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_link_valid <= '0;
            r_port_known <= '0;
            r_port_up    <= '0;
            r_adv_time   <= '0;
            r_adv_seq    <= '0;
            r_timeout    <= nlta_pkg::STALE_TIMEOUT_RST;
            r_idx        <= '0;
            r_chk_pend   <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take the timeout register
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end

            // Advance the scan pointer, one read a cycle
            if (w_accept) begin
                r_idx      <= '0;
                r_chk_pend <= 1'b0;
            end else if (r_state == nlta_pkg::S_SCAN) begin
                r_idx      <= r_idx + 1'b1;
                r_chk_pend <= 1'b1;
            end else begin
                r_chk_pend <= 1'b0;
            end

            // Mark a reported link valid, drop aged links
            if (r_state == nlta_pkg::S_RPT_CHK) begin
                r_link_valid[r_port] <= 1'b1;
            end
            if ((r_op == nlta_pkg::OP_SWEEP) && w_stale) begin
                r_link_valid[r_chk_idx] <= 1'b0;
            end

            // Record a changed local port status
            if ((r_state == nlta_pkg::S_STAT) && w_stat_chg) begin
                r_port_known[r_port] <= 1'b1;
                r_port_up[r_port]    <= r_online;
            end

            // Hand over the result and stamp the advert
            if ((r_state == nlta_pkg::S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                if (r_res_adv) begin
                    r_adv_time <= w_adv_time;
                    r_adv_seq  <= w_adv_seq;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture and result assembly
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;

        if (w_accept) begin
            r_op        <= nlta_pkg::t_op'(i_op);
            r_port      <= i_port_index;
            r_mac       <= i_nbr_mac;
            r_online    <= i_port_online;
            r_now       <= i_now_ms;
            r_res_adv   <= 1'b0;
            r_res_found <= 1'b0;
            r_res_port  <= '0;
            r_removed   <= '0;
        end else begin
            if (r_state == nlta_pkg::S_RPT_CHK) begin
                r_res_adv <= w_rpt_chg;
            end
            if (r_state == nlta_pkg::S_STAT) begin
                r_res_adv <= w_stat_chg;
            end
            if ((r_state == nlta_pkg::S_DRAIN) && (r_op == nlta_pkg::OP_SWEEP)) begin
                r_res_adv <= 1'b1;
            end
            if ((r_op == nlta_pkg::OP_SWEEP) && w_stale) begin
                r_removed <= r_removed + 1'b1;
            end
            // Keep only the first, lowest match
            if ((r_op == nlta_pkg::OP_LOOKUP) && w_hit && !r_res_found) begin
                r_res_found <= 1'b1;
                r_res_port  <= r_chk_idx;
            end
        end

        if ((r_state == nlta_pkg::S_DONE) && w_out_free) begin
            o_adv_sent      <= r_res_adv;
            o_adv_time      <= r_res_adv ? w_adv_time : '0;
            o_adv_seq       <= r_res_adv ? w_adv_seq : '0;
            o_found         <= r_res_found;
            o_found_port    <= r_res_port;
            o_stale_removed <= r_removed;
        end
    end

    // Assertions
    `include "neighbor_link_table_with_aging_macros.svh"

    `NLTA_ASSERT_IMPL(a_quiet_fields, o_out_valid && !o_adv_sent, (o_adv_time == '0) && (o_adv_seq == '0), "advert fields set without an advert")
    `NLTA_ASSERT_IMPL(a_found_alone, o_out_valid && o_found, !o_adv_sent && (o_stale_removed == '0), "lookup result mixed with other results")
    `NLTA_ASSERT_IMPL(a_removed_bound, o_out_valid, o_stale_removed <= nlta_pkg::CNT_W'(nlta_pkg::PORT_COUNT), "removed count exceeds table size")
    `NLTA_ASSERT_NEXT(a_adv_step, (r_state == nlta_pkg::S_DONE) && w_out_free && r_res_adv, (r_adv_time >= $past(r_adv_time)) && ((r_adv_time != $past(r_adv_time)) || (r_adv_seq == $past(r_adv_seq) + 1'b1)), "advert stamp did not advance")

endmodule

`default_nettype wire
